// ===== src/hcie_pkg.sv =====
// Shared types, constants and mnemonic tables of the Hack C-instruction encoder.
// No dependencies; every other file of the block imports this package.
package hcie_pkg;

	// Operation kinds passed from the front to the back
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_DEST   = 2'd1;
	localparam logic [1:0] OP_COMP   = 2'd2;
	localparam logic [1:0] OP_LONG   = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_DEST = 3'd1;
	localparam logic [2:0] ERR_COMP = 3'd2;
	localparam logic [2:0] ERR_JUMP = 3'd3;
	localparam logic [2:0] ERR_LONG = 3'd4;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_EQ   = "=";
	localparam logic [7:0] CH_SEMI = ";";
	localparam logic [7:0] CH_A    = "A";
	localparam logic [7:0] CH_D    = "D";
	localparam logic [7:0] CH_M    = "M";

	localparam logic [2:0] WORD_PREFIX = 3'b111;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int COMP_ENTRIES = 28;
	localparam int JUMP_ENTRIES = 7;

	typedef struct packed {
		logic [1:0] kind;     // OP_* code
		logic [7:0] ch;       // character to append
		logic       last;     // last character of the line
		logic       jump_sec; // line is in its jump part after this item
	} op_t;

	typedef struct packed {
		logic [1:0]  len;
		logic [23:0] txt;  // first character in the top byte
		logic [6:0]  code;
	} mnem_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] code;
	} lookup_t;

	localparam mnem_t COMP_TAB [COMP_ENTRIES] = '{
		'{2'd1, {"0", 16'h0}, 7'h2A}, '{2'd1, {"1", 16'h0}, 7'h3F},
		'{2'd2, {"-1", 8'h0}, 7'h3A}, '{2'd1, {"D", 16'h0}, 7'h0C},
		'{2'd1, {"A", 16'h0}, 7'h30}, '{2'd1, {"M", 16'h0}, 7'h70},
		'{2'd2, {"!D", 8'h0}, 7'h0D}, '{2'd2, {"!A", 8'h0}, 7'h31},
		'{2'd2, {"!M", 8'h0}, 7'h71}, '{2'd2, {"-D", 8'h0}, 7'h0F},
		'{2'd2, {"-A", 8'h0}, 7'h33}, '{2'd2, {"-M", 8'h0}, 7'h73},
		'{2'd3, "D+1", 7'h1F}, '{2'd3, "A+1", 7'h37}, '{2'd3, "M+1", 7'h77},
		'{2'd3, "D-1", 7'h0E}, '{2'd3, "A-1", 7'h32}, '{2'd3, "M-1", 7'h72},
		'{2'd3, "D+A", 7'h02}, '{2'd3, "D+M", 7'h42}, '{2'd3, "D-A", 7'h13},
		'{2'd3, "D-M", 7'h53}, '{2'd3, "A-D", 7'h07}, '{2'd3, "M-D", 7'h47},
		'{2'd3, "D&A", 7'h00}, '{2'd3, "D&M", 7'h40}, '{2'd3, "D|A", 7'h15},
		'{2'd3, "D|M", 7'h55}
	};

	localparam mnem_t JUMP_TAB [JUMP_ENTRIES] = '{
		'{2'd3, "JGT", 7'd1}, '{2'd3, "JEQ", 7'd2}, '{2'd3, "JGE", 7'd3},
		'{2'd3, "JLT", 7'd4}, '{2'd3, "JNE", 7'd5}, '{2'd3, "JLE", 7'd6},
		'{2'd3, "JMP", 7'd7}
	};

	// Match a token of n characters (n = 0: no match possible)
	function automatic logic entry_match(input mnem_t e, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2, input logic [1:0] n);
		return (n != 2'd0) && (n == e.len) && (c0 == e.txt[23:16]) &&
			((n < 2'd2) || (c1 == e.txt[15:8])) && ((n < 2'd3) || (c2 == e.txt[7:0]));
	endfunction

	function automatic lookup_t comp_lookup(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [1:0] n);
		lookup_t r;
		r = '0;
		for (int i = 0; i < COMP_ENTRIES; i++) begin
			if (entry_match(COMP_TAB[i], c0, c1, c2, n)) begin
				r.hit  = 1'b1;
				r.code = COMP_TAB[i].code;
			end
		end
		return r;
	endfunction

	function automatic lookup_t jump_lookup(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [1:0] n);
		lookup_t r;
		r = '0;
		for (int i = 0; i < JUMP_ENTRIES; i++) begin
			if (entry_match(JUMP_TAB[i], c0, c1, c2, n)) begin
				r.hit  = 1'b1;
				r.code = JUMP_TAB[i].code;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/hack_c_instruction_encoder.sv =====
// Top level of the Hack C-instruction encoder (dest=comp;jump, one char per item).
// Instantiates hcie_front, hcie_queue and hcie_back; depends on hcie_pkg.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+----------------------------------
//  input   | char_valid | char_stall | char_code[7:0], end_of_line
//  output  | word_valid | word_stall | instruction_word[15:0], error_code[2:0]
//
// One character item per cycle while the queue is not full; the back end settles
// one queued item per cycle unless an end-of-line item waits on a stalled output,
// and a two-entry queue sits between front and back; each line's result is registered.
// arst_n clears the line state, the queue and the output valid bit.
// A stalled output holds its item; further characters queue until the
// next end-of-line item needs the output register and the queue fills, then char_stall rises.
module hack_c_instruction_encoder import hcie_pkg::*; #(
	parameter int TOKEN_CHARS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_line,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [15:0] instruction_word,
	output logic [2:0]  error_code
);

	op_t  front_op;
	op_t  head_op;
	logic accept;
	logic q_nonempty;
	logic q_full;
	logic q_pop;

	// Hold input while the queue is full
	assign char_stall = q_full;
	assign accept     = char_valid && !char_stall;

	hcie_front #(
		.TOKEN_CHARS(TOKEN_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (char_code),
		.end_of_line(end_of_line),
		.op         (front_op)
	);

	hcie_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_op (front_op),
		.pop     (q_pop),
		.head    (head_op),
		.nonempty(q_nonempty),
		.full    (q_full)
	);

	hcie_back #(
		.TOKEN_CHARS(TOKEN_CHARS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (head_op),
		.op_valid        (q_nonempty),
		.op_pop          (q_pop),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.instruction_word(instruction_word),
		.error_code      (error_code)
	);

`ifndef NO_ASSERTIONS
	// An errored line never carries an encoded word
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && error_code != ERR_NONE) |-> (instruction_word == 16'h0000))
		else $error("errored line with nonzero word");

	// A clean line always carries the C-instruction prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && error_code == ERR_NONE) |-> (instruction_word[15:13] == WORD_PREFIX))
		else $error("clean line without prefix");

	// Closing a line must load the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && head_op.last) |=> word_valid)
		else $error("end of line popped but no result");

	// Error codes stay within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (error_code <= ERR_LONG))
		else $error("undefined error code");
`endif

endmodule

// ===== src/hcie_front.sv =====
// Front end: accepts characters and classifies each into an operation.
// Tracks line section and token length; depends on hcie_pkg.
module hcie_front import hcie_pkg::*; #(
	parameter int TOKEN_CHARS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       end_of_line,
	output op_t        op
);

	localparam int LEN_W = $clog2(TOKEN_CHARS + 1);

	logic [1:0]       section_q;
	logic [LEN_W-1:0] len_q;

	always_comb begin
		op.ch   = char_code;
		op.last = end_of_line;
		if (char_code == CH_EQ && section_q == 2'd0) begin
			op.kind = OP_DEST;
		end else if (char_code == CH_SEMI && section_q < 2'd2) begin
			op.kind = OP_COMP;
		end else if (len_q < LEN_W'(TOKEN_CHARS)) begin
			op.kind = OP_APPEND;
		end else begin
			op.kind = OP_LONG;
		end
		op.jump_sec = (op.kind == OP_COMP) || (section_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q <= 2'd0;
			len_q     <= '0;
		end else if (accept) begin
			if (end_of_line) begin
				section_q <= 2'd0;
				len_q     <= '0;
			end else begin
				case (op.kind)
					OP_DEST: begin
						section_q <= 2'd1;
						len_q     <= '0;
					end
					OP_COMP: begin
						section_q <= 2'd2;
						len_q     <= '0;
					end
					OP_APPEND: len_q <= len_q + 1'b1;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== src/hcie_queue.sv =====
// Two-entry queue of operations between front and back.
// Depends on hcie_pkg for op_t and the queue depth.
module hcie_queue import hcie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head,
	output logic nonempty,
	output logic full
);

	op_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign head     = slot_q[rd_q];
	assign nonempty = (count_q != '0);
	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/hcie_back.sv =====
// Back end: keeps the token, decodes dest/comp/jump and registers the result.
// Depends on hcie_pkg for op codes, error codes and mnemonic lookups.
module hcie_back import hcie_pkg::*; #(
	parameter int TOKEN_CHARS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  logic        op_valid,
	output logic        op_pop,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [15:0] instruction_word,
	output logic [2:0]  error_code
);

	localparam int LEN_W = $clog2(TOKEN_CHARS + 1);
	localparam int IDX_W = $clog2(TOKEN_CHARS);

	logic [7:0]       tok_q [TOKEN_CHARS];
	logic [LEN_W-1:0] len_q;
	logic [2:0]       dest_q;
	logic [6:0]       comp_q;
	logic [2:0]       perr_q;

	logic [15:0] word_q;
	logic [2:0]  code_q;
	logic        valid_q;

	logic             out_free;
	logic [1:0]       n_cur;
	logic [1:0]       n_next;
	logic [LEN_W-1:0] len_next;
	logic [7:0]       nb0, nb1, nb2;
	logic [2:0]       dest_scan;
	logic             dest_bad;
	lookup_t          semi_lk;
	lookup_t          fin_comp_lk;
	lookup_t          fin_jump_lk;
	logic [2:0]       dest_next;
	logic [6:0]       comp_next;
	logic [2:0]       step_err;
	logic [2:0]       err_run;
	logic [6:0]       comp_out;
	logic [2:0]       jump_out;
	logic [2:0]       fin_err;
	logic [2:0]       err_out;

	assign out_free = !valid_q || !word_stall;
	assign op_pop   = op_valid && (!op.last || out_free);

	// Scan the destination token
	always_comb begin
		dest_scan = 3'b000;
		dest_bad  = 1'b0;
		for (int k = 0; k < TOKEN_CHARS; k++) begin
			if (LEN_W'(k) < len_q) begin
				case (tok_q[k])
					CH_A:    dest_scan[2] = 1'b1;
					CH_D:    dest_scan[1] = 1'b1;
					CH_M:    dest_scan[0] = 1'b1;
					default: dest_bad = 1'b1;
				endcase
			end
		end
	end

	always_comb begin
		n_cur = (len_q <= LEN_W'(3)) ? len_q[1:0] : 2'd0;
		case (op.kind)
			OP_APPEND:       len_next = len_q + 1'b1;
			OP_DEST, OP_COMP: len_next = '0;
			default:         len_next = len_q;
		endcase
		n_next = (len_next <= LEN_W'(3)) ? len_next[1:0] : 2'd0;
		// Token as it stands after this item
		nb0 = (op.kind == OP_APPEND && len_q == LEN_W'(0)) ? op.ch : tok_q[0];
		nb1 = (op.kind == OP_APPEND && len_q == LEN_W'(1)) ? op.ch : tok_q[1];
		nb2 = (op.kind == OP_APPEND && len_q == LEN_W'(2)) ? op.ch : tok_q[2];
	end

	assign semi_lk     = comp_lookup(tok_q[0], tok_q[1], tok_q[2], n_cur);
	assign fin_comp_lk = comp_lookup(nb0, nb1, nb2, n_next);
	assign fin_jump_lk = jump_lookup(nb0, nb1, nb2, n_next);

	always_comb begin
		dest_next = dest_q;
		comp_next = comp_q;
		step_err  = ERR_NONE;
		case (op.kind)
			OP_DEST: begin
				dest_next = dest_scan;
				step_err  = dest_bad ? ERR_DEST : ERR_NONE;
			end
			OP_COMP: begin
				comp_next = semi_lk.hit ? semi_lk.code : 7'd0;
				step_err  = semi_lk.hit ? ERR_NONE : ERR_COMP;
			end
			OP_LONG: step_err = ERR_LONG;
			default: ;
		endcase
		err_run = (perr_q != ERR_NONE) ? perr_q : step_err;

		// Close the line
		comp_out = comp_next;
		jump_out = 3'b000;
		fin_err  = ERR_NONE;
		if (!op.jump_sec) begin
			comp_out = fin_comp_lk.hit ? fin_comp_lk.code : 7'd0;
			fin_err  = fin_comp_lk.hit ? ERR_NONE : ERR_COMP;
		end else if (len_next != '0) begin
			jump_out = fin_jump_lk.hit ? fin_jump_lk.code[2:0] : 3'b000;
			fin_err  = fin_jump_lk.hit ? ERR_NONE : ERR_JUMP;
		end
		err_out = (err_run != ERR_NONE) ? err_run : fin_err;
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.kind == OP_APPEND) begin
			tok_q[len_q[IDX_W-1:0]] <= op.ch;
		end
		if (op_pop && op.last) begin
			word_q <= (err_out != ERR_NONE) ? 16'h0000 :
				{WORD_PREFIX, comp_out, dest_next, jump_out};
			code_q <= err_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			dest_q  <= '0;
			comp_q  <= '0;
			perr_q  <= ERR_NONE;
			valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				if (op.last) begin
					len_q  <= '0;
					dest_q <= '0;
					comp_q <= '0;
					perr_q <= ERR_NONE;
				end else begin
					len_q  <= len_next;
					dest_q <= dest_next;
					comp_q <= comp_next;
					perr_q <= err_run;
				end
			end
			if (op_pop && op.last) begin
				valid_q <= 1'b1;
			end else if (!word_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign word_valid       = valid_q;
	assign instruction_word = word_q;
	assign error_code       = code_q;

endmodule

// ===== test/hack_c_instruction_encoder_test.sv =====
// Testbench of hack_c_instruction_encoder: directed assembly lines, then random ones.
// Results are checked against the behavioral encoder below or a typed row's own result.
// Depends on hcie_pkg (error codes, separator and register letters) and the block's RTL.

`timescale 1ns / 100ps

module hack_c_instruction_encoder_test;
	import hcie_pkg::*;

	localparam int TOKEN_LEN     = 3;
	localparam int RANDOM_ITEMS  = 525;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LIMIT_NS      = 5_000_000;
	localparam int PAUSE_LINE    = 45;

	// Where the line stands: no separator yet, after '=', after ';'
	typedef enum logic [1:0] {SEC_OPEN, SEC_AFTER_EQ, SEC_AFTER_SEMI} section_t;

	typedef struct packed {
		logic [15:0] word;
		logic [2:0]  err;
	} enc_result_t;

	// Mnemonic table: text left-justified, unused bytes zero
	typedef struct packed {
		logic        jump;
		logic [1:0]  n;
		logic [23:0] txt;
		logic [6:0]  code;
	} mnemonic_rec_t;

	localparam int MNEMONIC_COUNT = 35;
	localparam int COMP_LAST      = 27;
	localparam mnemonic_rec_t MNEMONICS [MNEMONIC_COUNT] = '{
		'{1'b0, 2'd1, {"0", 16'h0}, 7'h2A}, '{1'b0, 2'd1, {"1", 16'h0}, 7'h3F},
		'{1'b0, 2'd2, {"-1", 8'h0}, 7'h3A}, '{1'b0, 2'd1, {"D", 16'h0}, 7'h0C},
		'{1'b0, 2'd1, {"A", 16'h0}, 7'h30}, '{1'b0, 2'd1, {"M", 16'h0}, 7'h70},
		'{1'b0, 2'd2, {"!D", 8'h0}, 7'h0D}, '{1'b0, 2'd2, {"!A", 8'h0}, 7'h31},
		'{1'b0, 2'd2, {"!M", 8'h0}, 7'h71}, '{1'b0, 2'd2, {"-D", 8'h0}, 7'h0F},
		'{1'b0, 2'd2, {"-A", 8'h0}, 7'h33}, '{1'b0, 2'd2, {"-M", 8'h0}, 7'h73},
		'{1'b0, 2'd3, "D+1", 7'h1F}, '{1'b0, 2'd3, "A+1", 7'h37},
		'{1'b0, 2'd3, "M+1", 7'h77}, '{1'b0, 2'd3, "D-1", 7'h0E},
		'{1'b0, 2'd3, "A-1", 7'h32}, '{1'b0, 2'd3, "M-1", 7'h72},
		'{1'b0, 2'd3, "D+A", 7'h02}, '{1'b0, 2'd3, "D+M", 7'h42},
		'{1'b0, 2'd3, "D-A", 7'h13}, '{1'b0, 2'd3, "D-M", 7'h53},
		'{1'b0, 2'd3, "A-D", 7'h07}, '{1'b0, 2'd3, "M-D", 7'h47},
		'{1'b0, 2'd3, "D&A", 7'h00}, '{1'b0, 2'd3, "D&M", 7'h40},
		'{1'b0, 2'd3, "D|A", 7'h15}, '{1'b0, 2'd3, "D|M", 7'h55},
		'{1'b1, 2'd3, "JGT", 7'd1}, '{1'b1, 2'd3, "JEQ", 7'd2},
		'{1'b1, 2'd3, "JGE", 7'd3}, '{1'b1, 2'd3, "JLT", 7'd4},
		'{1'b1, 2'd3, "JNE", 7'd5}, '{1'b1, 2'd3, "JLE", 7'd6},
		'{1'b1, 2'd3, "JMP", 7'd7}
	};

	// Directed lines: text right-justified, n characters, last one marks end of line.
	// Rows with typed set carry the result written out by hand.
	typedef struct packed {
		logic [2:0]  n;
		logic [47:0] txt;
		logic        typed;
		logic [15:0] word;
		logic [2:0]  err;
	} line_row_t;

	localparam int DIRECTED_COUNT = 9;
	localparam line_row_t DIRECTED_LINES [DIRECTED_COUNT] = '{
		'{3'd1, "0",     1'b1, 16'hEA80, ERR_NONE},  // plain comp, nothing else
		'{3'd1, 48'hFF,  1'b1, 16'h0000, ERR_COMP},  // top byte value
		'{3'd1, 48'h00,  1'b1, 16'h0000, ERR_COMP},  // bottom byte value
		'{3'd1, "=",     1'b1, 16'h0000, ERR_COMP},  // separator last, comp empty
		'{3'd5, "DD=D;", 1'b0, 16'h0000, ERR_NONE},  // repeated dest letter, empty jump
		'{3'd5, "D;JGT", 1'b0, 16'h0000, ERR_NONE},  // no dest, with jump
		'{3'd3, "X=;",   1'b1, 16'h0000, ERR_DEST},  // bad dest wins over empty comp
		'{3'd4, "DDDD",  1'b1, 16'h0000, ERR_LONG},  // overlong token
		'{3'd4, "0;J=",  1'b1, 16'h0000, ERR_JUMP}   // '=' in the jump part is a plain char
	};

	// Characters that steer the parser, favored by the noise generator
	localparam int SPICE_COUNT = 14;
	localparam logic [8*SPICE_COUNT-1:0] SPICE = "ADM=;!-+|&01JG";

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  char_code;
	logic        end_of_line;
	logic        word_valid;
	logic        word_stall;
	logic [15:0] instruction_word;
	logic [2:0]  error_code;

	hack_c_instruction_encoder #(
		.TOKEN_CHARS(TOKEN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.end_of_line(end_of_line),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.instruction_word(instruction_word),
		.error_code(error_code)
	);

	// Behavioral encoder state, one line at a time
	logic [23:0] tok_text;
	logic [1:0]  tok_len;
	section_t    sect;
	logic [2:0]  dest_acc;
	logic [6:0]  comp_acc;
	logic [2:0]  first_err;

	enc_result_t expected_words[$];
	logic [7:0]  line_bytes[$];
	int          mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops a result
	initial begin
		#(LIMIT_NS);
		$display("FAIL hack_c_instruction_encoder");
		$finish;
	end

	function automatic void clear_line();
		tok_text  = '0;
		tok_len   = '0;
		sect      = SEC_OPEN;
		dest_acc  = '0;
		comp_acc  = '0;
		first_err = ERR_NONE;
	endfunction

	// Keep only the first error of a line
	function automatic void note_error(input logic [2:0] code);
		if (first_err == ERR_NONE)
			first_err = code;
	endfunction

	function automatic logic find_mnemonic(input logic jump_part, output logic [6:0] code);
		find_mnemonic = 1'b0;
		code = '0;
		for (int i = 0; i < MNEMONIC_COUNT; i++) begin
			if (MNEMONICS[i].jump == jump_part && MNEMONICS[i].n == tok_len &&
					MNEMONICS[i].txt == tok_text) begin
				find_mnemonic = 1'b1;
				code = MNEMONICS[i].code;
			end
		end
	endfunction

	function automatic void close_comp();
		logic [6:0] code;
		if (find_mnemonic(1'b0, code)) begin
			comp_acc = code;
		end else begin
			comp_acc = '0;
			note_error(ERR_COMP);
		end
	endfunction

	// Advance the encoder by one accepted character; queue the word at end of line
	task automatic encode_char(input logic [7:0] ch, input logic eol);
		logic [6:0] code;
		logic [2:0] jump_bits;
		logic [15:0] word;
		jump_bits = '0;
		if (ch == CH_EQ && sect == SEC_OPEN) begin
			dest_acc = '0;
			for (int k = 0; k < tok_len; k++) begin
				case (tok_text[23 - 8*k -: 8])
					CH_A: dest_acc |= 3'b100;
					CH_D: dest_acc |= 3'b010;
					CH_M: dest_acc |= 3'b001;
					default: note_error(ERR_DEST);
				endcase
			end
			tok_text = '0;
			tok_len  = '0;
			sect     = SEC_AFTER_EQ;
		end else if (ch == CH_SEMI && sect != SEC_AFTER_SEMI) begin
			close_comp();
			tok_text = '0;
			tok_len  = '0;
			sect     = SEC_AFTER_SEMI;
		end else if (tok_len < TOKEN_LEN) begin
			tok_text[23 - 8*tok_len -: 8] = ch;
			tok_len++;
		end else begin
			// buffer full: drop the character
			note_error(ERR_LONG);
		end

		if (eol) begin
			if (sect != SEC_AFTER_SEMI) begin
				close_comp();
			end else if (tok_len != 0) begin
				if (find_mnemonic(1'b1, code))
					jump_bits = code[2:0];
				else
					note_error(ERR_JUMP);
			end
			// an empty jump leaves the dest bits as they are
			word = (first_err == ERR_NONE) ? {WORD_PREFIX, comp_acc, dest_acc, jump_bits} : '0;
			expected_words.push_back('{word: word, err: first_err});
			clear_line();
		end
	endtask

	// Offer one character at a falling edge, hold it until taken, return at the next
	// falling edge. A typed row replaces the computed result with the one written out.
	task automatic offer_char(input logic [7:0] ch, input logic eol, input int gap,
			input logic typed, input logic [15:0] tword, input logic [2:0] terr);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid  <= 1'b1;
		char_code   <= ch;
		end_of_line <= eol;
		do @(posedge clk); while (char_stall);
		encode_char(ch, eol);
		if (typed && eol)
			expected_words[$] = '{word: tword, err: terr};
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1) == 0)
			return SPICE[8*$urandom_range(0, SPICE_COUNT - 1) +: 8];
		return 8'($urandom_range(0, 255));
	endfunction

	// Build one random line: mostly well-formed dest=comp;jump, some of it corrupted,
	// the rest plain noise
	task automatic build_line();
		int idx;
		int n;
		line_bytes.delete();
		if ($urandom_range(0, 99) < 75) begin
			if ($urandom_range(0, 2) != 0) begin
				n = $urandom_range(0, 3);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: line_bytes.push_back(CH_A);
						1: line_bytes.push_back(CH_D);
						default: line_bytes.push_back(CH_M);
					endcase
				end
				line_bytes.push_back(CH_EQ);
			end
			idx = $urandom_range(0, COMP_LAST);
			for (int k = 0; k < MNEMONICS[idx].n; k++)
				line_bytes.push_back(MNEMONICS[idx].txt[23 - 8*k -: 8]);
			if ($urandom_range(0, 1) == 0) begin
				line_bytes.push_back(CH_SEMI);
				if ($urandom_range(0, 3) != 0) begin
					idx = $urandom_range(COMP_LAST + 1, MNEMONIC_COUNT - 1);
					for (int k = 0; k < MNEMONICS[idx].n; k++)
						line_bytes.push_back(MNEMONICS[idx].txt[23 - 8*k -: 8]);
				end
			end
			// corrupt one character now and then
			if ($urandom_range(0, 4) == 0)
				line_bytes[$urandom_range(0, line_bytes.size() - 1)] = pick_byte();
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) line_bytes.push_back(pick_byte());
		end
	endtask

	// Compare one accepted result with the oldest expectation
	function automatic void check_word();
		enc_result_t want;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result, actual word %h err %0d",
				$time, instruction_word, error_code);
			mismatches++;
		end else begin
			want = expected_words.pop_front();
			if (instruction_word !== want.word) begin
				$display("%0t: instruction_word expected %h actual %h",
					$time, want.word, instruction_word);
				mismatches++;
			end
			if (error_code !== want.err) begin
				$display("%0t: error_code expected %0d actual %0d",
					$time, want.err, error_code);
				mismatches++;
			end
		end
	endfunction

	// Result side: draw a stall before each result, run quiet stretches now and then,
	// and twice hold off long enough for the block to back up into char_stall
	initial begin : word_sink
		int hold;
		int quiet;
		int words_seen;
		word_stall = 1'b0;
		quiet = 0;
		words_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (words_seen == 30 || words_seen == 70) begin
				hold = LONG_HOLD;
			end else if (quiet > 0) begin
				hold = 0;
				quiet--;
			end else begin
				hold = $urandom_range(0, 9);
				if ($urandom_range(0, 7) == 0)
					quiet = $urandom_range(4, 10);
			end
			if (hold > 0) begin
				word_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			word_stall <= 1'b0;
			do @(posedge clk); while (!word_valid);
			check_word();
			words_seen++;
		end
	end

	// Character side: reset, directed lines, random lines, then drain
	initial begin : char_source
		int sent;
		int lines;
		int quiet_lines;
		int gap;
		line_row_t row;
		char_valid  = 1'b0;
		char_code   = '0;
		end_of_line = 1'b0;
		arst_n      = 1'b0;
		clear_line();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines, one character per item
		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			row = DIRECTED_LINES[r];
			for (int k = 0; k < row.n; k++) begin
				offer_char(row.txt[8*(row.n - 1 - k) +: 8], k == row.n - 1,
					$urandom_range(0, 9), row.typed, row.word, row.err);
			end
		end

		// Random lines; runs of lines go back to back with no gaps
		sent = 0;
		lines = 0;
		quiet_lines = 0;
		while (sent < RANDOM_ITEMS) begin
			build_line();
			if (lines == PAUSE_LINE) begin
				// drop valid and wait until every queued result is out
				char_valid <= 1'b0;
				wait (expected_words.size() == 0);
				@(negedge clk);
			end
			if (quiet_lines > 0)
				quiet_lines--;
			else if ($urandom_range(0, 7) == 0)
				quiet_lines = $urandom_range(3, 8);
			for (int k = 0; k < line_bytes.size(); k++) begin
				gap = (quiet_lines > 0) ? 0 : $urandom_range(0, 9);
				offer_char(line_bytes[k], k == line_bytes.size() - 1, gap,
					1'b0, '0, ERR_NONE);
			end
			sent += line_bytes.size();
			lines++;
		end
		char_valid <= 1'b0;

		// Let the last results out, then watch a while for strays
		wait (expected_words.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS hack_c_instruction_encoder");
		else
			$display("FAIL hack_c_instruction_encoder");
		$finish;
	end

endmodule

// ===== sim.f =====
src/hcie_pkg.sv
src/hcie_front.sv
src/hcie_queue.sv
src/hcie_back.sv
src/hack_c_instruction_encoder.sv
test/hack_c_instruction_encoder_test.sv
